// File: design/gss_pkg.sv
package gss_pkg;

    localparam int GRID_SIDE_DEF = 4;
    localparam int CELL_W        = 4;
    localparam int NUM_CELLS     = 16;
    localparam int PULSE_W       = 16;
    localparam int CFG_DATA_W    = 16;
    localparam int CFG_IDX_W     = 2;
    localparam int CTRL_W        = 9;
    localparam int CELL_SUM_W    = 8;

    localparam logic [PULSE_W-1:0] PULSE_LEN_RST = 16'd48;

    // control level bit positions
    localparam int B_RUN       = 0;
    localparam int B_RESET     = 1;
    localparam int B_RIGHT     = 2;
    localparam int B_LEFT      = 3;
    localparam int B_DOWN      = 4;
    localparam int B_UP        = 5;
    localparam int B_RANDOM    = 6;
    localparam int B_REPEAT    = 7;
    localparam int B_RANDOMIZE = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_GATE_MODE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PITCH_IGN  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PULSE_LEN  = 2'd2;

    typedef enum logic [1:0] {
        GM_TRIGGER    = 2'd0,
        GM_RETRIGGER  = 2'd1,
        GM_CONTINUOUS = 2'd2
    } t_gate_mode;

    typedef enum logic [1:0] {
        DIR_RIGHT = 2'd0,
        DIR_LEFT  = 2'd1,
        DIR_DOWN  = 2'd2,
        DIR_UP    = 2'd3
    } t_dir;

    typedef struct packed {
        logic                 run_level;
        logic                 reset_level;
        logic                 right_level;
        logic                 left_level;
        logic                 down_level;
        logic                 up_level;
        logic                 random_move_level;
        logic                 repeat_level;
        logic                 randomize_gates_level;
        logic [NUM_CELLS-1:0] cell_toggle_levels;
        logic [1:0]           random_direction;
        logic [NUM_CELLS-1:0] random_gate_mask;
    } t_in_item;

    typedef struct packed {
        logic              gate_out;
        logic [CELL_W-1:0] current_cell;
        logic              pitch_refresh;
        logic              running_flag;
    } t_out_item;

    typedef struct packed {
        logic step;
        logic load_mask;
    } t_step_ctl;

endpackage

// File: design/gss_ctrl.sv
module gss_ctrl #(
    parameter int GRID_SIDE = gss_pkg::GRID_SIDE_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_accept,
    input  gss_pkg::t_in_item           i_item,
    output gss_pkg::t_step_ctl          o_ctl,
    output logic                        o_running,
    output logic [gss_pkg::CELL_W-1:0]  o_cell
);

    localparam int PW = (GRID_SIDE > 2) ? $clog2(GRID_SIDE) : 1;
    localparam logic [PW-1:0] POS_MAX = PW'(GRID_SIDE - 1);

    logic [gss_pkg::CTRL_W-1:0] r_prev, n_prev;
    logic                       r_running, n_running;
    logic [PW-1:0]              r_col, n_col;
    logic [PW-1:0]              r_row, n_row;
    logic [gss_pkg::CELL_W-1:0] r_cell, n_cell;

    logic [gss_pkg::CTRL_W-1:0]     lv;
    logic [gss_pkg::CTRL_W-1:0]     rise;
    logic [gss_pkg::CELL_SUM_W-1:0] cell_sum;
    logic                           step;
    logic                           load_mask;

    always_comb begin
        lv[gss_pkg::B_RUN]       = i_item.run_level;
        lv[gss_pkg::B_RESET]     = i_item.reset_level;
        lv[gss_pkg::B_RIGHT]     = i_item.right_level;
        lv[gss_pkg::B_LEFT]      = i_item.left_level;
        lv[gss_pkg::B_DOWN]      = i_item.down_level;
        lv[gss_pkg::B_UP]        = i_item.up_level;
        lv[gss_pkg::B_RANDOM]    = i_item.random_move_level;
        lv[gss_pkg::B_REPEAT]    = i_item.repeat_level;
        lv[gss_pkg::B_RANDOMIZE] = i_item.randomize_gates_level;
    end

    // moves apply in a fixed order, each one on top of the previous
    always_comb begin
        rise      = lv & ~r_prev;
        n_running = r_running ^ rise[gss_pkg::B_RUN];
        n_prev    = {r_prev[gss_pkg::CTRL_W-1:2], lv[1:0]};
        n_col     = r_col;
        n_row     = r_row;
        step      = 1'b0;
        load_mask = 1'b0;
        if (rise[gss_pkg::B_RESET]) begin
            n_col = '0;
            n_row = '0;
            step  = 1'b1;
        end
        if (n_running) begin
            n_prev[gss_pkg::CTRL_W-1:2] = lv[gss_pkg::CTRL_W-1:2];
            load_mask = rise[gss_pkg::B_RANDOMIZE];
            if (rise[gss_pkg::B_REPEAT]) begin
                step = 1'b1;
            end
            if (rise[gss_pkg::B_RANDOM]) begin
                step = 1'b1;
                case (i_item.random_direction)
                    gss_pkg::DIR_RIGHT: n_col = (n_col >= POS_MAX) ? '0 : n_col + 1'b1;
                    gss_pkg::DIR_LEFT:  n_col = (n_col == '0) ? POS_MAX : n_col - 1'b1;
                    gss_pkg::DIR_DOWN:  n_row = (n_row >= POS_MAX) ? '0 : n_row + 1'b1;
                    default:            n_row = (n_row == '0) ? POS_MAX : n_row - 1'b1;
                endcase
            end
            if (rise[gss_pkg::B_RIGHT]) begin
                step  = 1'b1;
                n_col = (n_col >= POS_MAX) ? '0 : n_col + 1'b1;
            end
            if (rise[gss_pkg::B_LEFT]) begin
                step  = 1'b1;
                n_col = (n_col == '0) ? POS_MAX : n_col - 1'b1;
            end
            if (rise[gss_pkg::B_DOWN]) begin
                step  = 1'b1;
                n_row = (n_row >= POS_MAX) ? '0 : n_row + 1'b1;
            end
            if (rise[gss_pkg::B_UP]) begin
                step  = 1'b1;
                n_row = (n_row == '0) ? POS_MAX : n_row - 1'b1;
            end
        end
        cell_sum = gss_pkg::CELL_SUM_W'(n_col)
                 + gss_pkg::CELL_SUM_W'(n_row) * gss_pkg::CELL_SUM_W'(GRID_SIDE);
        n_cell   = step ? cell_sum[gss_pkg::CELL_W-1:0] : r_cell;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev    <= '0;
            r_running <= 1'b1;
            r_col     <= '0;
            r_row     <= '0;
            r_cell    <= '0;
        end else if (i_accept) begin
            r_prev    <= n_prev;
            r_running <= n_running;
            r_col     <= n_col;
            r_row     <= n_row;
            r_cell    <= n_cell;
        end
    end

    assign o_ctl.step      = step;
    assign o_ctl.load_mask = load_mask;
    assign o_running       = n_running;
    assign o_cell          = n_cell;

`ifndef SYNTH
    a_cell_holds_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_accept |=> $stable(r_cell) && $stable(r_running))
        else $error("cell or run state changed without a beat");
    a_stopped_no_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !n_running |-> !load_mask)
        else $error("gate mask load while stopped");
`endif

endmodule

// File: design/gss_gate.sv
module gss_gate (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_accept,
    input  gss_pkg::t_step_ctl            i_ctl,
    input  logic [gss_pkg::NUM_CELLS-1:0] i_mask,
    input  logic [gss_pkg::NUM_CELLS-1:0] i_toggles,
    input  logic [gss_pkg::PULSE_W-1:0]   i_pulse_len,
    output logic                          o_pulse,
    output logic [gss_pkg::NUM_CELLS-1:0] o_enables
);

    logic [gss_pkg::PULSE_W-1:0]   r_remain, n_remain;
    logic [gss_pkg::NUM_CELLS-1:0] r_enables, n_enables;
    logic [gss_pkg::NUM_CELLS-1:0] r_prev_tog;

    logic [gss_pkg::PULSE_W-1:0]   remain_v;
    logic                          pulse;

    always_comb begin
        remain_v = r_remain;
        // a new step stretches the pulse, never shortens it
        if (i_ctl.step && (i_pulse_len > r_remain)) begin
            remain_v = i_pulse_len;
        end
        pulse     = (remain_v != '0);
        n_remain  = remain_v - gss_pkg::PULSE_W'(pulse);
        n_enables = (i_ctl.load_mask ? i_mask : r_enables) ^ (i_toggles & ~r_prev_tog);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_remain   <= '0;
            r_enables  <= '1;
            r_prev_tog <= '0;
        end else if (i_accept) begin
            r_remain   <= n_remain;
            r_enables  <= n_enables;
            r_prev_tog <= i_toggles;
        end
    end

    assign o_pulse   = pulse;
    assign o_enables = n_enables;

`ifndef SYNTH
    a_count_down: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && !i_ctl.step && r_remain != '0) |=> r_remain == $past(r_remain) - 1'b1)
        else $error("pulse count did not decrement");
`endif

endmodule

// File: design/grid_step_sequencer_core.sv
// grid step sequencer, one sample tick per input beat
// input channel: i_in_valid / o_in_ready with a t_in_item payload of control
//   levels, per-cell toggle levels and the random direction and gate mask
// output channel: o_out_valid / i_out_ready with a t_out_item payload of gate,
//   current cell, pitch refresh and running flag
// config port: i_cfg_we writes i_cfg_data to register i_cfg_idx
//   (0 gate mode, 1 pitch ignores gate, 2 pulse length); other indexes ignored
// timing: a result beat is registered and appears in the cycle after its input beat is taken
// throughput: one beat per cycle while the output is not stalled; all the per-tick work is a single pass of
//   edge detect, position update and pulse logic ahead of the output register
// stall: the output register holds its beat while i_out_ready is low and
//   o_in_ready drops only when that register is full and not being drained
// reset (synchronous, active low): running, all gates enabled, cell zero,
//   no pulse, pulse length 48, trigger mode, output register empty
module grid_step_sequencer_core #(
    parameter int GRID_SIDE = gss_pkg::GRID_SIDE_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  gss_pkg::t_in_item              i_in_data,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output gss_pkg::t_out_item             o_out_data,
    input  logic                           i_cfg_we,
    input  logic [gss_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [gss_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    logic [1:0]                    r_gate_mode;
    logic                          r_pitch_ign;
    logic [gss_pkg::PULSE_W-1:0]   r_pulse_len;
    logic                          r_out_valid;
    gss_pkg::t_out_item            r_out, n_out;

    logic                          accept;
    gss_pkg::t_step_ctl            ctl;
    logic                          running;
    logic [gss_pkg::CELL_W-1:0]    cur_cell;
    logic                          pulse;
    logic [gss_pkg::NUM_CELLS-1:0] enables;
    logic                          gate_on;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign accept     = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gate_mode <= gss_pkg::GM_TRIGGER;
            r_pitch_ign <= 1'b0;
            r_pulse_len <= gss_pkg::PULSE_LEN_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                gss_pkg::CFG_GATE_MODE: r_gate_mode <= i_cfg_data[1:0];
                gss_pkg::CFG_PITCH_IGN: r_pitch_ign <= i_cfg_data[0];
                gss_pkg::CFG_PULSE_LEN: r_pulse_len <= i_cfg_data[gss_pkg::PULSE_W-1:0];
                default: ;
            endcase
        end
    end

    gss_ctrl #(
        .GRID_SIDE (GRID_SIDE)
    ) u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (accept),
        .i_item    (i_in_data),
        .o_ctl     (ctl),
        .o_running (running),
        .o_cell    (cur_cell)
    );

    gss_gate u_gate (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_ctl       (ctl),
        .i_mask      (i_in_data.random_gate_mask),
        .i_toggles   (i_in_data.cell_toggle_levels),
        .i_pulse_len (r_pulse_len),
        .o_pulse     (pulse),
        .o_enables   (enables)
    );

    // unused mode code behaves as continuous
    always_comb begin
        gate_on = running && enables[cur_cell];
        case (r_gate_mode)
            gss_pkg::GM_TRIGGER:   gate_on = gate_on && pulse;
            gss_pkg::GM_RETRIGGER: gate_on = gate_on && !pulse;
            default:               gate_on = gate_on;
        endcase
        n_out.gate_out      = gate_on;
        n_out.current_cell  = cur_cell;
        n_out.pitch_refresh = gate_on || r_pitch_ign;
        n_out.running_flag  = running;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_out_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

`ifndef SYNTH
    a_beat_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> o_out_valid)
        else $error("accepted beat did not reach the output register");
    a_ready_only_when_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (o_out_valid && !i_out_ready))
        else $error("input held off without an output stall");
    a_refresh_follows_gate: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.gate_out |-> o_out_data.pitch_refresh
            && o_out_data.running_flag)
        else $error("gate high without refresh or while stopped");
`endif

endmodule
